// ===== src/hsvpw_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvpw_pkg
// Shared widths, codes and the bundle passed from the converter to the top.
// ----------------------------------------------------------------------------
package hsvpw_pkg;

  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned HUE_W    = 16;
  localparam int unsigned FIX_W    = 17;  // Q1.16 saturation and value
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ORDER_W  = 3;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned SCALED_W = 24;  // value * 255, Q.16
  localparam int unsigned WIDE_W   = 33;  // Q1.32 terms up to 2^32

  localparam int unsigned LED_COUNT_DEFAULT = 1024;

  localparam logic [FIX_W-1:0]  FIX_ONE  = 17'h1_0000;
  localparam logic [WIDE_W-1:0] WIDE_ONE = 33'h1_0000_0000;

  // hue sectors
  localparam logic [SECTOR_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BLU_MAG = 3'd4;

  // channel orders
  localparam logic [ORDER_W-1:0] ORDER_RGB = 3'd0;
  localparam logic [ORDER_W-1:0] ORDER_RBG = 3'd1;
  localparam logic [ORDER_W-1:0] ORDER_GRB = 3'd2;
  localparam logic [ORDER_W-1:0] ORDER_GBR = 3'd3;
  localparam logic [ORDER_W-1:0] ORDER_BRG = 3'd4;
  localparam logic [ORDER_W-1:0] ORDER_BGR = 3'd5;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [BYTE_W-1:0]   white;
    logic [SECTOR_W-1:0] sector;
    logic [BYTE_W-1:0]   v;
    logic [BYTE_W-1:0]   p;
    logic [BYTE_W-1:0]   q;
    logic [BYTE_W-1:0]   t;
  } conv_t;

endpackage

// ===== src/hsvpw_convert.sv =====
// ----------------------------------------------------------------------------
// hsvpw_convert
// Three-stage pipeline that forms the sector and the v, p, q and t bytes.
// ----------------------------------------------------------------------------
module hsvpw_convert #(
  parameter int unsigned LED_COUNT = hsvpw_pkg::LED_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [hsvpw_pkg::INDEX_W-1:0] led_index,
  input  logic [hsvpw_pkg::HUE_W-1:0]   hue,
  input  logic [hsvpw_pkg::FIX_W-1:0]   saturation,
  input  logic [hsvpw_pkg::FIX_W-1:0]   brightness,
  input  logic [hsvpw_pkg::BYTE_W-1:0]  white_level,
  output logic                          conv_valid,
  input  logic                          conv_ready,
  output hsvpw_pkg::conv_t              conv
);
  import hsvpw_pkg::*;

  localparam logic [FIX_W-1:0] LedLimit = FIX_W'(LED_COUNT);

  logic en1, en2, en3;

  // stage 1 registers
  logic                 s1_valid;
  logic [INDEX_W-1:0]   s1_index;
  logic [BYTE_W-1:0]    s1_white;
  logic [SECTOR_W-1:0]  s1_sector;
  logic [HUE_W-1:0]     s1_frac;
  logic [FIX_W-1:0]     s1_sat;
  logic [SCALED_W-1:0]  s1_scaled;

  // stage 2 registers
  logic                 s2_valid;
  logic [INDEX_W-1:0]   s2_index;
  logic [BYTE_W-1:0]    s2_white;
  logic [SECTOR_W-1:0]  s2_sector;
  logic [SCALED_W-1:0]  s2_scaled;
  logic [FIX_W-1:0]     s2_pdiff;
  logic [WIDE_W-1:0]    s2_qdiff;
  logic [WIDE_W-1:0]    s2_tdiff;

  // stage 1 logic
  logic                 in_range;
  logic [FIX_W-1:0]     sat_clamp;
  logic [FIX_W-1:0]     bright_clamp;
  logic [HUE_W+2:0]     hue6;
  logic [SCALED_W:0]    bright_x255;

  // stage 2 logic
  logic [FIX_W-1:0]     frac_inv;
  logic [WIDE_W-1:0]    frac_sat;
  logic [WIDE_W-1:0]    inv_sat;

  // stage 3 logic
  logic [SCALED_W+FIX_W-1:0]  p_prod;
  logic [SCALED_W+WIDE_W-1:0] q_prod;
  logic [SCALED_W+WIDE_W-1:0] t_prod;

  assign en3 = !conv_valid || conv_ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign pixel_stall = !en1;

  assign in_range     = {{(FIX_W-INDEX_W){1'b0}}, led_index} < LedLimit;
  assign sat_clamp    = (saturation > FIX_ONE) ? FIX_ONE : saturation;
  assign bright_clamp = (brightness > FIX_ONE) ? FIX_ONE : brightness;
  // hue * 6 as 4h + 2h
  assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  // value * 255 as 256v - v
  assign bright_x255 = {bright_clamp, 8'd0} - {8'd0, bright_clamp};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= pixel_valid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_index  <= led_index;
      s1_white  <= white_level;
      s1_sector <= hue6[HUE_W+2:HUE_W];
      s1_frac   <= hue6[HUE_W-1:0];
      s1_sat    <= sat_clamp;
      s1_scaled <= bright_x255[SCALED_W-1:0];
    end
  end

  assign frac_inv = FIX_ONE - {1'b0, s1_frac};
  assign frac_sat = WIDE_W'(s1_frac) * WIDE_W'(s1_sat);
  assign inv_sat  = WIDE_W'(frac_inv) * WIDE_W'(s1_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_index  <= s1_index;
      s2_white  <= s1_white;
      s2_sector <= s1_sector;
      s2_scaled <= s1_scaled;
      s2_pdiff  <= FIX_ONE - s1_sat;
      s2_qdiff  <= WIDE_ONE - frac_sat;
      s2_tdiff  <= WIDE_ONE - inv_sat;
    end
  end

  // every product shifted down lands in 0..255, so the low byte is exact
  assign p_prod = (SCALED_W+FIX_W)'(s2_scaled) * (SCALED_W+FIX_W)'(s2_pdiff);
  assign q_prod = (SCALED_W+WIDE_W)'(s2_scaled) * (SCALED_W+WIDE_W)'(s2_qdiff);
  assign t_prod = (SCALED_W+WIDE_W)'(s2_scaled) * (SCALED_W+WIDE_W)'(s2_tdiff);

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_valid <= 1'b0;
    end else if (en3) begin
      conv_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      conv.index  <= s2_index;
      conv.white  <= s2_white;
      conv.sector <= s2_sector;
      conv.v      <= s2_scaled[SCALED_W-1:16];
      conv.p      <= p_prod[39:32];
      conv.q      <= q_prod[55:48];
      conv.t      <= t_prod[55:48];
    end
  end

endmodule

// ===== src/hsv_to_rgb_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_writer
// HSV to RGB conversion with channel reordering for an LED strip buffer.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per pixel whose index is
// below LED_COUNT. Each pixel passes three math stages (hue sector and
// value scale, the saturation products, the wide byte products) and the
// output register, where the sector select and channel reorder sit.
// Pixels with an index at or beyond LED_COUNT are taken and dropped. Stall
// on the result side holds the whole pipeline; with no stall the rate is one
// pixel per cycle. Write channel_order through order_write and order_data
// only while no pixel is in flight (not enforced); codes 6 and 7 act as RGB.
module hsv_to_rgb_pixel_writer #(
  parameter int unsigned LED_COUNT = hsvpw_pkg::LED_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          order_write,
  input  logic [hsvpw_pkg::ORDER_W-1:0] order_data,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [hsvpw_pkg::INDEX_W-1:0] led_index,
  input  logic [hsvpw_pkg::HUE_W-1:0]   hue,
  input  logic [hsvpw_pkg::FIX_W-1:0]   saturation,
  input  logic [hsvpw_pkg::FIX_W-1:0]   brightness,
  input  logic [hsvpw_pkg::BYTE_W-1:0]  white_level,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [hsvpw_pkg::INDEX_W-1:0] target_index,
  output logic [hsvpw_pkg::BYTE_W-1:0]  first_byte,
  output logic [hsvpw_pkg::BYTE_W-1:0]  second_byte,
  output logic [hsvpw_pkg::BYTE_W-1:0]  third_byte,
  output logic [hsvpw_pkg::BYTE_W-1:0]  white_byte
);
  import hsvpw_pkg::*;

  logic [ORDER_W-1:0] channel_order;
  logic               conv_valid;
  logic               conv_ready;
  conv_t              conv;
  logic [BYTE_W-1:0]  red, green, blue;
  logic [BYTE_W-1:0]  c0, c1, c2;

  hsvpw_convert #(
    .LED_COUNT(LED_COUNT)
  ) u_convert (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .led_index  (led_index),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .white_level(white_level),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv       (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_order <= ORDER_RGB;
    end else if (order_write) begin
      channel_order <= order_data;
    end
  end

  always_comb begin
    unique case (conv.sector)
      SEC_RED_YEL: begin red = conv.v; green = conv.t; blue = conv.p; end
      SEC_YEL_GRN: begin red = conv.q; green = conv.v; blue = conv.p; end
      SEC_GRN_CYN: begin red = conv.p; green = conv.v; blue = conv.t; end
      SEC_CYN_BLU: begin red = conv.p; green = conv.q; blue = conv.v; end
      SEC_BLU_MAG: begin red = conv.t; green = conv.p; blue = conv.v; end
      default:     begin red = conv.v; green = conv.p; blue = conv.q; end
    endcase
  end

  always_comb begin
    unique case (channel_order)
      ORDER_RBG: begin c0 = red;   c1 = blue;  c2 = green; end
      ORDER_GRB: begin c0 = green; c1 = red;   c2 = blue;  end
      ORDER_GBR: begin c0 = green; c1 = blue;  c2 = red;   end
      ORDER_BRG: begin c0 = blue;  c1 = red;   c2 = green; end
      ORDER_BGR: begin c0 = blue;  c1 = green; c2 = red;   end
      default:   begin c0 = red;   c1 = green; c2 = blue;  end
    endcase
  end

  // output register frees up as soon as its result transfers
  assign conv_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (conv_ready) begin
      result_valid <= conv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_ready && conv_valid) begin
      target_index <= conv.index;
      first_byte   <= c0;
      second_byte  <= c1;
      third_byte   <= c2;
      white_byte   <= conv.white;
    end
  end

endmodule

// ===== sim/tb_hsv_to_rgb_pixel_writer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_pixel_writer
// Self-checking bench for the HSV to RGB pixel writer.
// ----------------------------------------------------------------------------
// A short table of directed pixels runs first: black, white, pure hues,
// saturation and brightness above one, and hues on the sector boundaries.
// Random pixels follow, in phases that each use another channel order,
// the two unused codes included. Each pixel transfer pushes the expected
// result, read off the table or worked out by a local bit-exact converter.
// Every result transfer is compared field by field with the oldest entry.
// Both sides idle in random bursts, the receiver once holds off long
// enough to back up the pipeline, and the last phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_pixel_writer;
  import hsvpw_pkg::*;

  localparam int unsigned STRIP_LEDS    = LED_COUNT_DEFAULT;
  localparam int unsigned DRAIN_CYCLES  = 10;   // pipeline depth plus margin
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASE_PIXELS  = 123;
  localparam int unsigned PHASE_COUNT   = 10;

  // codes with no named order, converted as RGB
  localparam logic [ORDER_W-1:0] ORDER_SPARE6 = 3'd6;
  localparam logic [ORDER_W-1:0] ORDER_SPARE7 = 3'd7;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [HUE_W-1:0]   hue;
    logic [FIX_W-1:0]   sat;
    logic [FIX_W-1:0]   bright;
    logic [BYTE_W-1:0]  white;
  } pixel_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  c0;
    logic [BYTE_W-1:0]  c1;
    logic [BYTE_W-1:0]  c2;
    logic [BYTE_W-1:0]  white;
  } rgbw_t;

  typedef struct packed {
    pixel_t px;
    logic   typed;
    rgbw_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic order_write = 1'b0;
  logic [ORDER_W-1:0] order_data = '0;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic [INDEX_W-1:0] led_index = '0;
  logic [HUE_W-1:0] hue = '0;
  logic [FIX_W-1:0] saturation = '0;
  logic [FIX_W-1:0] brightness = '0;
  logic [BYTE_W-1:0] white_level = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [INDEX_W-1:0] target_index;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;
  logic [BYTE_W-1:0] third_byte;
  logic [BYTE_W-1:0] white_byte;

  rgbw_t pixel_due[$];
  dir_row_t dir_rows[$];
  logic [ORDER_W-1:0] phase_orders [PHASE_COUNT];
  logic [ORDER_W-1:0] order_now = ORDER_RGB;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int fail_count = 0;

  hsv_to_rgb_pixel_writer #(
    .LED_COUNT(STRIP_LEDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .order_write(order_write),
    .order_data(order_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .led_index(led_index),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .white_level(white_level),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .target_index(target_index),
    .first_byte(first_byte),
    .second_byte(second_byte),
    .third_byte(third_byte),
    .white_byte(white_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] byte_of(input logic [63:0] x);
    return (x > 64'd255) ? 8'd255 : x[7:0];
  endfunction

  // bit-exact six-sector conversion; returns 0 when the index is off the strip
  function automatic bit hsv_to_rgbw(input pixel_t px, input logic [ORDER_W-1:0] order,
                                     output rgbw_t res);
    logic [63:0] sat, val, h6, f, w;
    logic [BYTE_W-1:0] v, p, q, t, r, g, b;
    logic [SECTOR_W-1:0] sector;
    res = '0;
    if (px.index >= STRIP_LEDS) return 1'b0;
    sat = 64'(px.sat);
    val = 64'(px.bright);
    if (sat > 64'd65536) sat = 64'd65536;
    if (val > 64'd65536) val = 64'd65536;
    h6 = 64'(px.hue);
    h6 = h6 * 64'd6;
    sector = h6[18:16];
    f = h6 & 64'hFFFF;
    w = val * 64'd255;
    v = byte_of(w >> 16);
    p = byte_of((w * (64'd65536 - sat)) >> 32);
    q = byte_of((w * ((64'd1 << 32) - f * sat)) >> 48);
    t = byte_of((w * ((64'd1 << 32) - (64'd65536 - f) * sat)) >> 48);
    case (sector)
      SEC_RED_YEL: begin r = v; g = t; b = p; end
      SEC_YEL_GRN: begin r = q; g = v; b = p; end
      SEC_GRN_CYN: begin r = p; g = v; b = t; end
      SEC_CYN_BLU: begin r = p; g = q; b = v; end
      SEC_BLU_MAG: begin r = t; g = p; b = v; end
      default:     begin r = v; g = p; b = q; end
    endcase
    res.index = px.index;
    res.white = px.white;
    case (order)
      ORDER_RBG: begin res.c0 = r; res.c1 = b; res.c2 = g; end
      ORDER_GRB: begin res.c0 = g; res.c1 = r; res.c2 = b; end
      ORDER_GBR: begin res.c0 = g; res.c1 = b; res.c2 = r; end
      ORDER_BRG: begin res.c0 = b; res.c1 = r; res.c2 = g; end
      ORDER_BGR: begin res.c0 = b; res.c1 = g; res.c2 = r; end
      default:   begin res.c0 = r; res.c1 = g; res.c2 = b; end
    endcase
    return 1'b1;
  endfunction

  function automatic void add_row(input int idx, input int h, input int s, input int v,
                                  input int wl, input int typed,
                                  input int b0, input int b1, input int b2);
    dir_row_t row;
    row.px.index  = INDEX_W'(idx);
    row.px.hue    = HUE_W'(h);
    row.px.sat    = FIX_W'(s);
    row.px.bright = FIX_W'(v);
    row.px.white  = BYTE_W'(wl);
    row.typed     = (typed != 0);
    row.res.index = INDEX_W'(idx);
    row.res.c0    = BYTE_W'(b0);
    row.res.c1    = BYTE_W'(b1);
    row.res.c2    = BYTE_W'(b2);
    row.res.white = BYTE_W'(wl);
    dir_rows.push_back(row);
  endfunction

  function automatic logic [FIX_W-1:0] random_fix();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 17'd0;
    if (sel == 1) return FIX_ONE;
    if (sel == 2) return FIX_W'($urandom_range(65537, 131071));
    return FIX_W'($urandom_range(0, 65536));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int bnd;
    if ($urandom_range(0, 19) == 0) px.index = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    else px.index = INDEX_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0) begin
      // land near a sector boundary, wrapping around zero
      bnd = ($urandom_range(0, 5) * 65536 + 5) / 6 + $urandom_range(0, 4) - 2;
      px.hue = bnd[HUE_W-1:0];
    end else begin
      px.hue = HUE_W'($urandom_range(0, 65535));
    end
    px.sat    = random_fix();
    px.bright = random_fix();
    px.white  = BYTE_W'($urandom_range(0, 255));
    return px;
  endfunction

  // offer one pixel and wait for its transfer, then queue what it should give
  task automatic send_pixel(input pixel_t px, input logic typed, input rgbw_t typed_res);
    rgbw_t due;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    led_index   <= px.index;
    hue         <= px.hue;
    saturation  <= px.sat;
    brightness  <= px.bright;
    white_level <= px.white;
    @(posedge clk);
    while (!(pixel_valid && !pixel_stall)) @(posedge clk);
    if (typed) pixel_due.push_back(typed_res);
    else if (hsv_to_rgbw(px, order_now, due)) pixel_due.push_back(due);
  endtask

  task automatic quiesce();
    pixel_valid <= 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] code);
    order_write <= 1'b1;
    order_data  <= code;
    @(posedge clk);
    order_write <= 1'b0;
    order_now = code;
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // result side: compare each transfer with the oldest pending pixel
  always @(posedge clk) begin
    rgbw_t exp_res;
    if (!rst && result_valid && !result_stall) begin
      if (pixel_due.size() == 0) begin
        $error("result transfer with no pixel pending, target_index %0d", target_index);
        fail_count++;
      end else begin
        exp_res = pixel_due.pop_front();
        check_field("target_index", int'(exp_res.index), int'(target_index));
        check_field("first_byte", int'(exp_res.c0), int'(first_byte));
        check_field("second_byte", int'(exp_res.c1), int'(second_byte));
        check_field("third_byte", int'(exp_res.c2), int'(third_byte));
        check_field("white_byte", int'(exp_res.white), int'(white_byte));
      end
    end
  end

  // receiver stall pattern
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    //      index  hue    sat     value   white  typed  expected bytes
    add_row(0,     0,     0,      0,      8'h00, 1,     0,   0,   0);    // black
    add_row(1023,  0,     0,      65536,  8'hff, 1,     255, 255, 255);  // white
    add_row(1,     0,     65536,  65536,  8'h5a, 1,     255, 0,   0);    // pure red
    add_row(2,     0,     131071, 65536,  8'ha5, 1,     255, 0,   0);    // saturation above one
    add_row(3,     0,     0,      131071, 8'h0f, 1,     255, 255, 255);  // brightness above one
    add_row(4,     32768, 65536,  65536,  8'hf0, 1,     0,   255, 255);  // cyan
    add_row(5,     0,     131071, 131071, 8'h01, 1,     255, 0,   0);
    add_row(6,     65535, 65536,  65536,  8'h80, 0,     0,   0,   0);
    add_row(7,     10922, 65536,  65536,  8'h7f, 0,     0,   0,   0);
    add_row(8,     10923, 65536,  65536,  8'h33, 0,     0,   0,   0);
    add_row(9,     21845, 50000,  60000,  8'hcc, 0,     0,   0,   0);
    add_row(10,    21846, 50000,  60000,  8'h3c, 0,     0,   0,   0);
    add_row(11,    43690, 30000,  65536,  8'hc3, 0,     0,   0,   0);
    add_row(12,    43691, 30000,  65536,  8'h69, 0,     0,   0,   0);
    add_row(13,    54613, 65535,  65535,  8'h96, 0,     0,   0,   0);
    add_row(14,    54614, 1,      1,      8'h11, 0,     0,   0,   0);
    add_row(10'h2aa, 16'haaaa, 17'h0aaaa, 17'h15555, 8'haa, 0, 0, 0, 0);
    add_row(10'h155, 16'h5555, 17'h15555, 17'h0aaaa, 8'h55, 0, 0, 0, 0);
    add_row(1000,  12345, 40000,  30000,  8'hc8, 0,     0,   0,   0);
    add_row(512,   65535, 65536,  256,    8'hee, 0,     0,   0,   0);

    phase_orders = '{ORDER_RBG, ORDER_GRB, ORDER_GBR, ORDER_BRG, ORDER_BGR,
                     ORDER_SPARE6, ORDER_SPARE7, ORDER_RGB, ORDER_BGR, ORDER_GRB};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].res);

    for (int k = 0; k < PHASE_COUNT; k++) begin
      quiesce();
      write_order(phase_orders[k]);
      if (k == PHASE_COUNT - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // back up the pipeline behind a long receiver hold
        if (k == 2 && n == 20) hold_request = 1'b1;
        // sender waits for every pending result mid-phase
        if (k == 4 && n == 60) quiesce();
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hsvpw_pkg.sv
src/hsvpw_convert.sv
src/hsv_to_rgb_pixel_writer.sv
sim/tb_hsv_to_rgb_pixel_writer.sv
